// ----- rtl/hvn_pkg.sv -----
package hvn_pkg;

    // Field widths.
    localparam int PosW     = 12;
    localparam int HgtW     = 16;
    localparam int GridW    = 13;
    localparam int StepW    = 16;
    localparam int NrmW     = 16;
    localparam int InDataW  = 2 * PosW + 5 * HgtW;
    localparam int OutDataW = 3 * NrmW;
    localparam int CfgDataW = 16;
    localparam int CfgIdxW  = 2;

    // Internal arithmetic widths.
    localparam int CompW = 19;                 // signed sum component
    localparam int MagW  = CompW - 1;          // component magnitude
    localparam int SqW   = 2 * MagW;           // squared magnitude
    localparam int SumW  = SqW + 2;            // sum of three squares
    localparam int AccW  = SqW + 32 + 8;       // signed remainder width
    localparam int QW    = 16;                 // quotient digits per lane

    localparam logic [GridW-1:0] MaxGridSize  = GridW'(4096);
    localparam logic [NrmW-1:0]  NormFallback = NrmW'(18919);
    localparam logic [NrmW-1:0]  NormMax      = NrmW'(32767);

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_STEP_X      = 2'd2,
        REG_STEP_Y      = 2'd3
    } cfg_reg_t;

    // Pipeline payloads.
    typedef struct packed {
        logic                      outside;
        logic [2:0]                neg;
        logic [2:0][MagW-1:0]      mag;
    } front_t;

    typedef struct packed {
        logic                      outside;
        logic [2:0]                neg;
        logic [2:0][SqW-1:0]       sq;
    } sq_t;

    typedef struct packed {
        logic                      outside;
        logic                      zero_len;
        logic [2:0]                neg;
        logic [2:0][SqW-1:0]       sq;
        logic [SumW-1:0]           s;
    } sum_t;

    typedef struct packed {
        logic                      outside;
        logic                      zero_len;
        logic [2:0]                neg;
        logic [SumW-1:0]           s;
        logic [2:0][AccW-1:0]      e;
        logic [2:0][AccW-1:0]      p;
        logic [2:0][QW-1:0]        m;
    } iter_t;

endpackage

// ----- rtl/heightfield_vertex_normal.sv -----
// Heightfield vertex normal: central-difference normal, scaled to unit length in Q1.15.
// Throughput: one vertex per cycle when the output is not stalled; 16 of the stages each
// resolve one quotient bit of the exact normalization for all three components in parallel.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register defaults.
module heightfield_vertex_normal (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [hvn_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [hvn_pkg::CfgDataW-1:0] cfg_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // pos_x, pos_y, height_center, height_left, height_right, height_down, height_up
    input  logic [hvn_pkg::InDataW-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // normal_x, normal_y, normal_z
    output logic [hvn_pkg::OutDataW-1:0] m_tdata,
    // status
    output logic [0:0]                   m_tuser
);
    import hvn_pkg::*;

    localparam int NStage = 21;
    localparam int SInit  = 3;
    localparam int SOut   = NStage - 1;

    // Configuration registers.
    logic [GridW-1:0] grid_w_reg, grid_h_reg;
    logic [StepW-1:0] step_x_reg, step_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_w_reg <= GridW'(2);
            grid_h_reg <= GridW'(2);
            step_x_reg <= StepW'(256);
            step_y_reg <= StepW'(256);
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_GRID_WIDTH:  grid_w_reg <= cfg_wdata[GridW-1:0];
                REG_GRID_HEIGHT: grid_h_reg <= cfg_wdata[GridW-1:0];
                REG_STEP_X:      step_x_reg <= cfg_wdata[StepW-1:0];
                REG_STEP_Y:      step_y_reg <= cfg_wdata[StepW-1:0];
                default: ;
            endcase
        end
    end

    // Per-stage valid bits and a ready chain that lets bubbles collapse.
    logic [NStage-1:0] vld_reg;
    logic [NStage:0]   adv;

    assign adv[NStage] = m_tready;
    for (genvar i = 0; i < NStage; i++) begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= s_tvalid;
            for (int i = 1; i < NStage; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[SOut];

    // Front stage: grid checks and the summed normal vector.
    front_t front_reg, front_next;

    always_comb begin
        logic [GridW-1:0]        w, h, px, py;
        logic signed [CompW-1:0] hc, hl, hr, hd, hu, nx, ny, nz, ax, ay, az;
        logic                    rt, lf, up, dn;
        w  = (grid_w_reg > MaxGridSize) ? MaxGridSize : grid_w_reg;
        h  = (grid_h_reg > MaxGridSize) ? MaxGridSize : grid_h_reg;
        px = GridW'(s_tdata[PosW-1:0]);
        py = GridW'(s_tdata[2*PosW-1:PosW]);
        hc = CompW'($signed(s_tdata[2*PosW+HgtW-1   -: HgtW]));
        hl = CompW'($signed(s_tdata[2*PosW+2*HgtW-1 -: HgtW]));
        hr = CompW'($signed(s_tdata[2*PosW+3*HgtW-1 -: HgtW]));
        hd = CompW'($signed(s_tdata[2*PosW+4*HgtW-1 -: HgtW]));
        hu = CompW'($signed(s_tdata[2*PosW+5*HgtW-1 -: HgtW]));
        rt = (px + GridW'(1)) < w;
        lf = (px != '0);
        up = (py + GridW'(1)) < h;
        dn = (py != '0);
        nx = (rt ? hc - hr : '0) + (lf ? hl - hc : '0);
        ny = (up ? hc - hu : '0) + (dn ? hd - hc : '0);
        nz = (rt ? CompW'(step_x_reg) : '0) + (lf ? CompW'(step_x_reg) : '0)
           + (up ? CompW'(step_y_reg) : '0) + (dn ? CompW'(step_y_reg) : '0);
        ax = nx[CompW-1] ? -nx : nx;
        ay = ny[CompW-1] ? -ny : ny;
        az = nz;
        front_next.outside = (px >= w) || (py >= h);
        front_next.neg     = {1'b0, ny[CompW-1], nx[CompW-1]};
        front_next.mag     = {az[MagW-1:0], ay[MagW-1:0], ax[MagW-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) front_reg <= front_next;
    end

    // Squares of the component magnitudes.
    sq_t sq_reg;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            sq_reg.outside <= front_reg.outside;
            sq_reg.neg     <= front_reg.neg;
            for (int l = 0; l < 3; l++) begin
                sq_reg.sq[l] <= SqW'(front_reg.mag[l]) * SqW'(front_reg.mag[l]);
            end
        end
    end

    // Squared length of the vector.
    sum_t sum_reg;

    always_ff @(posedge aclk) begin
        logic [SumW-1:0] s;
        s = SumW'(sq_reg.sq[0]) + SumW'(sq_reg.sq[1]) + SumW'(sq_reg.sq[2]);
        if (adv[2]) begin
            sum_reg.outside  <= sq_reg.outside;
            sum_reg.neg      <= sq_reg.neg;
            sum_reg.sq       <= sq_reg.sq;
            sum_reg.s        <= s;
            sum_reg.zero_len <= (s == '0);
        end
    end

    // Digit recurrence: the quotient m is the largest value with
    // (2m-1)^2 * s <= c^2 * 2^32. E holds the remainder and P holds (2m-1) * s.
    iter_t it_reg  [0:QW];
    iter_t it_next [0:QW];

    always_comb begin
        logic signed [AccW-1:0] s_ext;
        s_ext = $signed(AccW'(sum_reg.s));
        it_next[0].outside  = sum_reg.outside;
        it_next[0].zero_len = sum_reg.zero_len;
        it_next[0].neg      = sum_reg.neg;
        it_next[0].s        = sum_reg.s;
        for (int l = 0; l < 3; l++) begin
            it_next[0].e[l] = $signed(AccW'({sum_reg.sq[l], 32'b0})) - s_ext;
            it_next[0].p[l] = -s_ext;
            it_next[0].m[l] = '0;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_iter
        localparam int K = QW - 1 - j;

        always_comb begin
            logic signed [AccW-1:0] s_ext, t, d;
            s_ext = $signed(AccW'(it_reg[j].s));
            it_next[j+1] = it_reg[j];
            for (int l = 0; l < 3; l++) begin
                t = ($signed(it_reg[j].p[l]) <<< (K + 2)) + (s_ext <<< (2 * K + 2));
                d = $signed(it_reg[j].e[l]) - t;
                if (!d[AccW-1]) begin
                    it_next[j+1].m[l][K] = 1'b1;
                    it_next[j+1].e[l]    = d;
                    it_next[j+1].p[l]    = $signed(it_reg[j].p[l]) + (s_ext <<< (K + 1));
                end
            end
        end
    end

    for (genvar j = 0; j <= QW; j++) begin : g_it_reg
        always_ff @(posedge aclk) begin
            if (adv[SInit+j]) it_reg[j] <= it_next[j];
        end
    end

    // Output stage: sign, saturation and the special cases.
    logic [OutDataW-1:0] tdata_reg;
    logic                status_reg;

    always_ff @(posedge aclk) begin
        logic [OutDataW-1:0] d;
        logic [QW-1:0]       m;
        for (int l = 0; l < 3; l++) begin
            m = it_reg[QW].m[l];
            if (it_reg[QW].outside) begin
                d[l*NrmW +: NrmW] = '0;
            end else if (it_reg[QW].zero_len) begin
                d[l*NrmW +: NrmW] = NormFallback;
            end else if (it_reg[QW].neg[l]) begin
                d[l*NrmW +: NrmW] = -m;
            end else begin
                d[l*NrmW +: NrmW] = (m > NormMax) ? NormMax : m;
            end
        end
        if (adv[SOut]) begin
            tdata_reg  <= d;
            status_reg <= it_reg[QW].outside;
        end
    end

    assign m_tdata    = tdata_reg;
    assign m_tuser[0] = status_reg;

endmodule

// ----- rtl/hvn_checker.sv -----
module hvn_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [hvn_pkg::OutDataW-1:0] m_tdata,
    input logic [0:0]                   m_tuser
);
    import hvn_pkg::*;

    // A stalled result beat stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // An outside position carries a zero normal.
    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("outside position with nonzero normal");

    // The z component of a valid normal is never negative.
    a_z_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> !m_tdata[OutDataW-1])
        else $error("negative z component");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind heightfield_vertex_normal hvn_checker u_hvn_checker (.*);

// ----- dv/heightfield_vertex_normal_checker.sv -----
module heightfield_vertex_normal_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [hvn_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [hvn_pkg::CfgDataW-1:0] cfg_wdata,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [hvn_pkg::InDataW-1:0]  s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [hvn_pkg::OutDataW-1:0] m_tdata,
    input  logic [0:0]                   m_tuser,
    output int                           mismatches,
    output int                           pending
);
    import hvn_pkg::*;

    typedef struct packed {
        logic [NrmW-1:0] nx;
        logic [NrmW-1:0] ny;
        logic [NrmW-1:0] nz;
        logic            outside;
    } normal_t;

    logic [GridW-1:0] width_q;
    logic [GridW-1:0] height_q;
    logic [StepW-1:0] step_x_q;
    logic [StepW-1:0] step_y_q;
    normal_t          normal_queue[$];

    // Rounded round(32768 * c / sqrt(s)), found by bisection on exact squares.
    function automatic logic [NrmW-1:0] unit_scale(longint c, longint unsigned s);
        logic [127:0]    target;
        logic [127:0]    prod;
        longint unsigned mag;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        mag    = (c < 0) ? -c : c;
        target = 128'(mag * mag) << 32;
        lo     = 0;
        hi     = 32768;
        while (lo < hi) begin
            mid  = (lo + hi + 1) / 2;
            t    = 2 * mid - 1;
            prod = 128'(t * t) * 128'(s);
            if (prod <= target) lo = mid;
            else hi = mid - 1;
        end
        if (c < 0) return NrmW'(-lo);
        return (lo > 32767) ? NrmW'(32767) : NrmW'(lo);
    endfunction

    // Sum the edge cross products of the neighbors inside the grid, then normalize.
    function automatic normal_t vertex_normal(logic [InDataW-1:0] d);
        normal_t         r;
        longint unsigned px;
        longint unsigned py;
        longint          hc;
        longint          hl;
        longint          hr;
        longint          hd;
        longint          hu;
        longint unsigned w;
        longint unsigned h;
        longint          nx;
        longint          ny;
        longint          nz;
        longint unsigned s;
        px = d[11:0];
        py = d[23:12];
        hc = longint'($signed(d[39:24]));
        hl = longint'($signed(d[55:40]));
        hr = longint'($signed(d[71:56]));
        hd = longint'($signed(d[87:72]));
        hu = longint'($signed(d[103:88]));
        w  = (width_q > MaxGridSize) ? MaxGridSize : width_q;
        h  = (height_q > MaxGridSize) ? MaxGridSize : height_q;
        r  = '0;
        nx = 0;
        ny = 0;
        nz = 0;
        if (px >= w || py >= h) begin
            r.outside = 1'b1;
            return r;
        end
        if (px + 1 < w) begin nx += hc - hr; nz += step_x_q; end
        if (py + 1 < h) begin ny += hc - hu; nz += step_y_q; end
        if (px > 0) begin nx += hl - hc; nz += step_x_q; end
        if (py > 0) begin ny += hd - hc; nz += step_y_q; end
        s = nx * nx + ny * ny + nz * nz;
        if (s == 0) begin
            r.nx = NormFallback;
            r.ny = NormFallback;
            r.nz = NormFallback;
        end else begin
            r.nx = unit_scale(nx, s);
            r.ny = unit_scale(ny, s);
            r.nz = unit_scale(nz, s);
        end
        return r;
    endfunction

    // Track register writes, predict accepted vertices and compare result beats.
    always @(posedge aclk) begin
        normal_t want;
        normal_t got;
        if (!aresetn) begin
            width_q  <= GridW'(2);
            height_q <= GridW'(2);
            step_x_q <= StepW'(256);
            step_y_q <= StepW'(256);
            normal_queue.delete();
            mismatches <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_GRID_WIDTH: width_q <= cfg_wdata[GridW-1:0];
                    REG_GRID_HEIGHT: height_q <= cfg_wdata[GridW-1:0];
                    REG_STEP_X: step_x_q <= cfg_wdata;
                    REG_STEP_Y: step_y_q <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) normal_queue.push_back(vertex_normal(s_tdata));
            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser[0]};
                if (normal_queue.size() == 0) begin
                    $display("%0t: unexpected result beat, actual %h", $time, got);
                    mismatches <= mismatches + 1;
                end else begin
                    want = normal_queue.pop_front();
                    if (want !== got) begin
                        $display({"%0t: normal mismatch, expected x=%h y=%h z=%h st=%b,",
                                  " actual x=%h y=%h z=%h st=%b"},
                                 $time, want.nx, want.ny, want.nz, want.outside,
                                 got.nx, got.ny, got.nz, got.outside);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
        pending <= normal_queue.size();
    end

endmodule

// ----- dv/heightfield_vertex_normal_tb.sv -----
module heightfield_vertex_normal_tb;
    import hvn_pkg::*;

    localparam int CycleLimit = 600000;
    localparam int DrainWait  = 40;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;
    logic [0:0]          m_tuser;
    int                  mismatches;
    int                  pending;
    int                  cycles;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    bit                  hold_req;
    int                  grid_w;
    int                  grid_h;

    heightfield_vertex_normal u_dut (.*);

    heightfield_vertex_normal_checker u_checker (.*);

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("heightfield_vertex_normal test failed");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_req) begin
            m_tready <= 1'b0;
            repeat (300) @(posedge aclk);
            hold_req = 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [InDataW-1:0] pack_vertex(int px, int py, int hc, int hl,
                                                       int hr, int hd, int hu);
        return {16'(hu), 16'(hd), 16'(hr), 16'(hl), 16'(hc), 12'(py), 12'(px)};
    endfunction

    // Offer one vertex beat, with random idle cycles ahead of it.
    task automatic send_vertex(logic [InDataW-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(cfg_reg_t idx, int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CfgDataW'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait for the pipeline to empty, then load a new grid setting.
    task automatic set_grid(int w, int h, int sx, int sy);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_STEP_X, sx);
        write_reg(REG_STEP_Y, sy);
        grid_w = w;
        grid_h = h;
    endtask

    function automatic int pick_pos(int dim);
        case ($urandom_range(9))
            0: return 0;
            1: return (dim - 1 > 4095) ? 4095 : dim - 1;
            2: return $urandom_range(4095);
            default: return $urandom_range((dim - 1 > 4095) ? 4095 : dim - 1);
        endcase
    endfunction

    function automatic int pick_height(int base);
        case ($urandom_range(7))
            0: return 32767;
            1: return -32768;
            2, 3: return base + $signed($urandom_range(512)) - 256;
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    task automatic random_vertices(int count);
        int hc;
        repeat (count) begin
            hc = $signed(16'($urandom()));
            send_vertex(pack_vertex(pick_pos(grid_w), pick_pos(grid_h), hc, pick_height(hc),
                                    pick_height(hc), pick_height(hc), pick_height(hc)));
        end
    endtask

    // Stimulus and verdict.
    initial begin
        cycles         = 0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        grid_w         = 2;
        grid_h         = 2;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed vertices on the reset grid: corners, flat, extremes, outside.
        send_vertex(pack_vertex(0, 0, 0, 0, 0, 0, 0));
        send_vertex(pack_vertex(1, 1, 100, 100, 100, 100, 100));
        send_vertex(pack_vertex(0, 1, -32768, 32767, 32767, 32767, 32767));
        send_vertex(pack_vertex(1, 0, 32767, -32768, -32768, -32768, -32768));
        send_vertex(pack_vertex(2, 0, 5, 5, 5, 5, 5));
        send_vertex(pack_vertex(0, 2, 5, 5, 5, 5, 5));
        send_vertex(pack_vertex(4095, 4095, -1, -1, -1, -1, -1));

        // Large grid, steepest steps and every position bit.
        set_grid(4096, 4096, 65535, 65535);
        send_vertex(pack_vertex(4095, 4095, 0, 0, 0, 0, 0));
        send_vertex(pack_vertex(2048, 1365, 32767, -32768, 32767, -32768, 32767));
        send_vertex(pack_vertex(2730, 4095, -32768, 32767, -32768, 32767, -32768));
        send_vertex(pack_vertex(0, 2048, 0, 32767, -32768, 32767, -32768));

        // Tiny step: the normal lies almost in the plane.
        set_grid(2, 4096, 1, 65535);
        send_vertex(pack_vertex(0, 17, 0, 0, 32767, 0, 0));
        send_vertex(pack_vertex(1, 4095, -32768, 32767, 0, 32767, 0));
        send_vertex(pack_vertex(1, 100, 0, 0, 0, 0, 0));
        send_vertex(pack_vertex(3, 100, 0, 0, 0, 0, 0));
        set_grid(4096, 2, 1, 1);
        send_vertex(pack_vertex(700, 1, 32767, -32768, 32767, -32768, 32767));
        send_vertex(pack_vertex(700, 1, 3, 3, 3, 3, 3));
        send_vertex(pack_vertex(700, 2, 3, 3, 3, 3, 3));

        // Random phases over several settings and idling mixes.
        set_grid(100, 37, 256, 256);
        random_vertices(250);
        send_idle_pct = 60;
        set_grid(4096, 4096, 65535, 1);
        random_vertices(220);
        send_idle_pct  = 0;
        recv_stall_pct = 60;
        set_grid(2, 2, 1, 65535);
        random_vertices(220);
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        set_grid($urandom_range(4096, 2), $urandom_range(4096, 2),
                 $urandom_range(65535, 1), $urandom_range(65535, 1));
        random_vertices(220);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_grid($urandom_range(64, 2), $urandom_range(64, 2),
                 $urandom_range(4096, 1), $urandom_range(4096, 1));
        random_vertices(200);

        // Long hold-off on the result side while vertices keep coming.
        hold_req = 1'b1;
        random_vertices(120);
        recv_stall_pct = 30;
        send_idle_pct  = 30;
        set_grid($urandom_range(4096, 2), $urandom_range(4096, 2),
                 $urandom_range(65535, 1), $urandom_range(65535, 1));
        random_vertices(300);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("heightfield_vertex_normal test passed");
        end else begin
            $display("heightfield_vertex_normal test failed");
        end
        $finish;
    end

endmodule
